FILE: design/swhms_pkg.sv
// Shared types and constants for the hh:mm:ss stopwatch button controller.
package swhms_pkg;

    // Last count value before each field wraps to zero.
    localparam logic [5:0] SECONDS_LAST = 6'd59;
    localparam logic [5:0] MINUTES_LAST = 6'd59;
    localparam logic [4:0] HOURS_LAST   = 5'd23;

    // Reset value of the long-press threshold in milliseconds.
    localparam logic [15:0] LONG_PRESS_RESET = 16'd500;

    // One input sample as held in the input register.
    typedef struct packed {
        logic        button_level;
        logic [5:0]  rtc_second;
        logic [31:0] now_ms;
    } sample_t;

    // One result as held in the output register.
    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       running;
    } result_t;

endpackage

FILE: design/swhms_in_stage.sv
// Input register stage: captures one request and holds it until the core takes it.
module swhms_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  swhms_pkg::sample_t in_sample,
    input  logic              take,
    output logic              held_valid,
    output swhms_pkg::sample_t held_sample
);
    import swhms_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    sample_t sample_reg;
    logic    accept;

    // The stage is free when empty or when its request moves on this cycle.
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, loaded only on an accepted request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= in_sample;
        end
    end

    assign held_valid  = valid_reg;
    assign held_sample = sample_reg;

endmodule

FILE: design/swhms_core.sv
// Stopwatch state: tick handling, button handling and the threshold register.
module swhms_core #(
    parameter int STAMP_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  swhms_pkg::sample_t sample,
    input  logic               cfg_write,
    input  logic [15:0]        cfg_data,
    output swhms_pkg::result_t result
);
    import swhms_pkg::*;

    logic [15:0]            long_press_reg;
    logic [5:0]             seconds_reg;
    logic [5:0]             seconds_next;
    logic [5:0]             minutes_reg;
    logic [5:0]             minutes_next;
    logic [4:0]             hours_reg;
    logic [4:0]             hours_next;
    logic                   run_reg;
    logic                   run_next;
    logic                   button_reg;
    logic [STAMP_WIDTH-1:0] press_start_reg;
    logic                   sec_seen_reg;
    logic [5:0]             prev_sec_reg;

    logic                   sec_changed;
    logic                   advance;
    logic [5:0]             tick_seconds;
    logic [5:0]             tick_minutes;
    logic [4:0]             tick_hours;
    logic [STAMP_WIDTH-1:0] now_stamp;
    logic [STAMP_WIDTH-1:0] press_dur;
    logic                   short_press;
    logic                   rising;
    logic                   falling;

    // Tick: a new RTC seconds value advances the count while running.
    assign sec_changed = !sec_seen_reg || (sample.rtc_second != prev_sec_reg);
    assign advance     = sec_changed && run_reg;

    always_comb
    begin
        tick_seconds = seconds_reg;
        tick_minutes = minutes_reg;
        tick_hours   = hours_reg;
        if (advance)
        begin
            if (seconds_reg == SECONDS_LAST)
            begin
                tick_seconds = 6'd0;
                if (minutes_reg == MINUTES_LAST)
                begin
                    tick_minutes = 6'd0;
                    tick_hours   = (hours_reg == HOURS_LAST) ? 5'd0 : hours_reg + 5'd1;
                end
                else
                begin
                    tick_minutes = minutes_reg + 6'd1;
                end
            end
            else
            begin
                tick_seconds = seconds_reg + 6'd1;
            end
        end
    end

    // The result shows the count after the tick, before the button.
    assign result.hours   = tick_hours;
    assign result.minutes = tick_minutes;
    assign result.seconds = tick_seconds;
    assign result.running = run_reg;

    // Button: press duration is kept modulo the timestamp width.
    assign now_stamp   = sample.now_ms[STAMP_WIDTH-1:0];
    assign press_dur   = now_stamp - press_start_reg;
    assign short_press = press_dur < {{(STAMP_WIDTH-16){1'b0}}, long_press_reg};
    assign rising      = !button_reg && sample.button_level;
    assign falling     = button_reg && !sample.button_level;

    always_comb
    begin
        seconds_next = tick_seconds;
        minutes_next = tick_minutes;
        hours_next   = tick_hours;
        run_next     = run_reg;
        if (falling)
        begin
            if (short_press)
            begin
                run_next = !run_reg;
            end
            else
            begin
                run_next     = 1'b0;
                seconds_next = 6'd0;
                minutes_next = 6'd0;
                hours_next   = 5'd0;
            end
        end
    end

    // State registers, updated once per request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seconds_reg     <= 6'd0;
            minutes_reg     <= 6'd0;
            hours_reg       <= 5'd0;
            run_reg         <= 1'b0;
            button_reg      <= 1'b0;
            press_start_reg <= '0;
            sec_seen_reg    <= 1'b0;
            prev_sec_reg    <= 6'd0;
        end
        else if (step)
        begin
            seconds_reg  <= seconds_next;
            minutes_reg  <= minutes_next;
            hours_reg    <= hours_next;
            run_reg      <= run_next;
            button_reg   <= sample.button_level;
            sec_seen_reg <= 1'b1;
            prev_sec_reg <= sample.rtc_second;
            if (rising)
            begin
                press_start_reg <= now_stamp;
            end
        end
    end

    // Long-press threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_write)
        begin
            long_press_reg <= cfg_data;
        end
    end

endmodule

FILE: design/swhms_out_stage.sv
// Output register stage: holds one result until the receiver takes it.
module swhms_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  swhms_pkg::result_t load_result,
    output logic               can_load,
    output logic               out_valid,
    input  logic               out_stall,
    output swhms_pkg::result_t out_result
);
    import swhms_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // A new result may enter when the register is empty or being drained.
    assign can_load = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

FILE: design/stopwatch_hms_button_control_unit.sv
// Top level of the hh:mm:ss stopwatch with single-button run and long-press clear.
//
// Input channel (in_valid / in_stall): one request per sample of button level,
// RTC seconds and millisecond timestamp. Output channel (out_valid / out_stall):
// one result per request with the count after the tick and the run flag, both
// before the button of that sample is applied.
// Configuration channel (cfg_valid / cfg_ready / cfg_data): writes the long-press
// threshold in milliseconds; cfg_ready is always high. Write it while idle.
// An accepted request is held in the input register, passes through the tick and
// button logic and is then registered in the result register.
// Throughput: one request per cycle while out_stall is low; the tick and button
// logic between the input register and the result register is combinational.
// Stall: while out_stall is high a full result register holds. If the input
// register is empty, one more request is still taken into it; while it holds a
// request, in_stall is high.
// Reset (rst_n low, asynchronous): both stages empty, count cleared, paused,
// button released, no RTC second seen, threshold 500 ms.
module stopwatch_hms_button_control_unit #(
    parameter int STAMP_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        button_level,
    input  logic [5:0]  rtc_second,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  shown_hours,
    output logic [5:0]  shown_minutes,
    output logic [5:0]  shown_seconds,
    output logic        is_running,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import swhms_pkg::*;

    sample_t in_sample;
    sample_t held_sample;
    logic    held_valid;
    logic    can_load;
    logic    take;
    result_t core_result;
    result_t out_result;

    assign in_sample.button_level = button_level;
    assign in_sample.rtc_second   = rtc_second;
    assign in_sample.now_ms       = now_ms;

    // A request moves from the input register to the result register.
    assign take      = held_valid && can_load;
    assign cfg_ready = 1'b1;

    swhms_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_sample   (in_sample),
        .take        (take),
        .held_valid  (held_valid),
        .held_sample (held_sample)
    );

    swhms_core #(
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (take),
        .sample    (held_sample),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .result    (core_result)
    );

    swhms_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (take),
        .load_result (core_result),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_result  (out_result)
    );

    assign shown_hours   = out_result.hours;
    assign shown_minutes = out_result.minutes;
    assign shown_seconds = out_result.seconds;
    assign is_running    = out_result.running;

    // A shown count is always a valid time of day.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (shown_hours <= HOURS_LAST) && (shown_minutes <= MINUTES_LAST)
                      && (shown_seconds <= SECONDS_LAST))
    else $error("shown count out of range");

    // The input side stalls only when the result register is full and held.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

    // A request that leaves the input register yields a result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid)
    else $error("processed request produced no result");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the hh:mm:ss stopwatch button controller.
module tb;
    import swhms_pkg::*;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        button_level = 1'b0;
    logic [5:0]  rtc_second = 6'd0;
    logic [31:0] now_ms = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  shown_hours;
    logic [5:0]  shown_minutes;
    logic [5:0]  shown_seconds;
    logic        is_running;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'd0;

    stopwatch_hms_button_control_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .button_level  (button_level),
        .rtc_second    (rtc_second),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .shown_hours   (shown_hours),
        .shown_minutes (shown_minutes),
        .shown_seconds (shown_seconds),
        .is_running    (is_running),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Samples waiting to be sent and displays the stopwatch should show.
    sample_t pending_samples[$];
    result_t expected_display[$];
    int      error_count = 0;
    int      queued_total = 0;
    bit      steady = 1'b0;

    // Our own copy of the stopwatch state and the threshold.
    bit [5:0]  watch_sec = '0;
    bit [5:0]  watch_min = '0;
    bit [4:0]  watch_hr = '0;
    bit        watch_run = 1'b0;
    bit        watch_btn = 1'b0;
    bit [31:0] watch_press = '0;
    bit [7:0]  watch_last_rsec = 8'd255;
    bit [15:0] press_limit = LONG_PRESS_RESET;

    // Stimulus generator state.
    bit        gen_level = 1'b0;
    bit [5:0]  gen_rsec = '0;
    bit [31:0] gen_now = '0;
    bit [15:0] gen_thr = LONG_PRESS_RESET;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Wait length drawn per request or result; none in steady stretches.
    function automatic int pause_len();
        return steady ? 0 : $urandom_range(0, 5);
    endfunction

    // Apply one accepted sample: tick first, record the display, then the button.
    task automatic advance_watch(input sample_t s);
        result_t shown;
        bit [31:0] held_ms;
        begin
            if ({2'b00, s.rtc_second} != watch_last_rsec)
            begin
                watch_last_rsec = {2'b00, s.rtc_second};
                if (watch_run)
                begin
                    if (watch_sec == SECONDS_LAST)
                    begin
                        watch_sec = '0;
                        if (watch_min == MINUTES_LAST)
                        begin
                            watch_min = '0;
                            watch_hr = (watch_hr == HOURS_LAST) ? 5'd0 : watch_hr + 5'd1;
                        end
                        else
                            watch_min = watch_min + 6'd1;
                    end
                    else
                        watch_sec = watch_sec + 6'd1;
                end
            end
            shown.hours = watch_hr;
            shown.minutes = watch_min;
            shown.seconds = watch_sec;
            shown.running = watch_run;
            expected_display.push_back(shown);

            if (!watch_btn && s.button_level)
                watch_press = s.now_ms;
            else if (watch_btn && !s.button_level)
            begin
                held_ms = s.now_ms - watch_press;
                if (held_ms < {16'd0, press_limit})
                    watch_run = ~watch_run;
                else
                begin
                    watch_run = 1'b0;
                    watch_sec = '0;
                    watch_min = '0;
                    watch_hr = '0;
                end
            end
            watch_btn = s.button_level;
        end
    endtask

    // Request driver: takes samples from the pending queue, holds them while stalled.
    sample_t sent_sample;
    int      gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_watch(sent_sample);
                gap_left = pause_len();
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left == 0 && pending_samples.size() > 0)
                begin
                    sent_sample = pending_samples.pop_front();
                    in_valid <= 1'b1;
                    button_level <= sent_sample.button_level;
                    rtc_second <= sent_sample.rtc_second;
                    now_ms <= sent_sample.now_ms;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left = gap_left - 1;
                end
            end
        end
    end

    // Result monitor: checks each accepted display and stalls at random afterwards.
    int hold_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_display.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result %0d:%0d:%0d run=%0d", shown_hours,
                                 shown_minutes, shown_seconds, is_running);
                end
                else
                begin
                    result_t want;
                    want = expected_display.pop_front();
                    if (want.hours !== shown_hours || want.minutes !== shown_minutes ||
                        want.seconds !== shown_seconds || want.running !== is_running)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"mismatch: expected %0d:%0d:%0d run=%0d, ",
                                      "got %0d:%0d:%0d run=%0d"},
                                     want.hours, want.minutes, want.seconds, want.running,
                                     shown_hours, shown_minutes, shown_seconds, is_running);
                    end
                end
                hold_left = pause_len();
            end
            else if (hold_left > 0)
                hold_left = hold_left - 1;
            out_stall <= (hold_left > 0);
        end
    end

    task automatic add_sample(input bit level, input bit [5:0] rsec, input bit [31:0] stamp);
        sample_t s;
        begin
            s.button_level = level;
            s.rtc_second = rsec;
            s.now_ms = stamp;
            pending_samples.push_back(s);
            queued_total++;
            gen_level = level;
            gen_rsec = rsec;
            gen_now = stamp;
        end
    endtask

    // Mostly the next second, sometimes no change, now and then an out-of-range value.
    function automatic bit [5:0] next_rsec();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return gen_rsec;
        if (pick == 1)
            return 6'($urandom_range(60, 63));
        return (gen_rsec >= 6'd59) ? 6'd0 : gen_rsec + 6'd1;
    endfunction

    // A full press and release with a hold time placed around the threshold.
    task automatic gen_press();
        bit [31:0] held;
        bit [31:0] t0;
        int        h;
        begin
            if (gen_level)
                add_sample(1'b0, next_rsec(), gen_now + $urandom_range(0, 50));
            case ($urandom_range(0, 6))
                0: held = (gen_thr == 0) ? 32'd0 : {16'd0, gen_thr} - 32'd1;
                1: held = {16'd0, gen_thr};
                2: held = {16'd0, gen_thr} + 32'd1;
                3, 4: held = $urandom_range(0, gen_thr);
                5: held = $urandom_range(0, 3 * gen_thr + 3);
                default: held = $urandom();
            endcase
            t0 = gen_now + $urandom_range(0, 2000);
            add_sample(1'b1, next_rsec(), t0);
            h = $urandom_range(0, 3);
            repeat (h)
                add_sample(1'b1, next_rsec(), t0 + $urandom_range(0, held));
            add_sample(1'b0, next_rsec(), t0 + held);
        end
    endtask

    // Random phase: mostly tick runs and presses, some raw noise.
    task automatic gen_phase(input int count);
        int target;
        int pick;
        begin
            target = queued_total + count;
            while (queued_total < target)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    repeat ($urandom_range(1, 10))
                        add_sample(gen_level, next_rsec(), gen_now + $urandom_range(0, 1500));
                else if (pick < 8)
                    gen_press();
                else
                    repeat ($urandom_range(1, 3))
                        add_sample(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                                   $urandom());
            end
        end
    endtask

    // The block is idle once nothing is queued, sent or outstanding.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_display.size() != 0);
    endtask

    task automatic write_threshold(input bit [15:0] ms);
        begin
            @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_data <= ms;
            do
                @(posedge clk);
            while (!cfg_ready);
            press_limit = ms;
            gen_thr = ms;
            cfg_valid <= 1'b0;
        end
    endtask

    // Main sequence: reset, directed cases, then random phases at several thresholds.
    initial
    begin
        bit [15:0] thr_list[5];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset threshold: first second seen, out-of-range seconds, timestamp wrap,
        // presses just under and exactly at the threshold.
        add_sample(1'b0, 6'd0, 32'd0);
        add_sample(1'b1, 6'd0, 32'd100);
        add_sample(1'b0, 6'd0, 32'd150);
        add_sample(1'b0, 6'd1, 32'd200);
        add_sample(1'b0, 6'd63, 32'd300);
        add_sample(1'b0, 6'd63, 32'd400);
        add_sample(1'b1, 6'd59, 32'hFFFF_FF00);
        add_sample(1'b0, 6'd0, 32'h0000_0010);
        add_sample(1'b0, 6'd1, 32'd20);
        add_sample(1'b1, 6'd1, 32'd1000);
        add_sample(1'b0, 6'd1, 32'd1499);
        add_sample(1'b0, 6'd2, 32'd1600);
        add_sample(1'b1, 6'd3, 32'd2000);
        add_sample(1'b0, 6'd4, 32'd2500);
        add_sample(1'b1, 6'd59, 32'hFFFF_FFFF);
        add_sample(1'b1, 6'd59, 32'd0);
        add_sample(1'b0, 6'd58, 32'hFFFF_FFFF);
        add_sample(1'b0, 6'd57, 32'd5);
        wait_idle();

        // Zero threshold: every release clears, even a press of no length.
        write_threshold(16'd0);
        @(negedge clk);
        add_sample(1'b1, 6'd56, 32'd7);
        add_sample(1'b0, 6'd56, 32'd7);
        add_sample(1'b1, 6'd55, 32'd9);
        add_sample(1'b0, 6'd54, 32'd3000);
        wait_idle();

        thr_list[0] = 16'd1;
        thr_list[1] = 16'hFFFF;
        thr_list[2] = 16'($urandom_range(2, 2000));
        thr_list[3] = LONG_PRESS_RESET;
        thr_list[4] = 16'($urandom_range(1, 65535));
        for (int i = 0; i < 5; i++)
        begin
            write_threshold(thr_list[i]);
            @(negedge clk);
            steady = (i % 2 == 1);
            gen_phase(100);
            wait_idle();
        end

        // Let any stray result show up before the verdict.
        repeat (8) @(posedge clk);
        if (expected_display.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
